// ===== rtl/rtc_pkg.sv =====
// Shared constants and types for the reference-counted tag cache.
package rtc_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Operation codes carried on the kind field
    typedef enum logic [1:0] {
        K_GET   = 2'd0,
        K_ALLOC = 2'd1,
        K_PUT   = 2'd2,
        K_EVICT = 2'd3
    } t_kind;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture input beat, restart scan
        logic step;   // examine one slot
        logic apply;  // commit the operation and load the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // slot under examination is the last one
    } t_sts;

endpackage

// ===== rtl/refcounted_tag_cache.sv =====
// Top level of the reference-counted tag cache.
// A table of 16 slots, each a valid flag, a 32-bit key and a 16-bit saturating
// reference count. Get, alloc and evict walk the table one slot per clock
// between a capture step and a commit step; put addresses its slot directly
// and goes from capture straight to commit. One operation is in flight at a
// time; the result sits in an output register, so the next beat is taken
// while a finished result still waits. Failures (miss, table full, slot still
// referenced, slot index out of range) return status 1 with slot and count
// zero.
module refcounted_tag_cache import rtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key,
    input  logic [3:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [3:0]  o_slot_out,
    output logic [15:0] o_count_out
);

    t_cmd cmd;
    t_sts sts;

    rtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rtc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_slot      (i_slot),
        .o_sts       (sts),
        .o_status    (o_status),
        .o_slot_out  (o_slot_out),
        .o_count_out (o_count_out)
    );

    // A failed operation reports no slot and no count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_slot_out == 4'd0 && o_count_out == 16'd0))
        else $error("failed result carries nonzero slot or count");

    // Only one operation in flight: an accepted beat blocks the next cycle
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an operation is in flight");

    // A new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced without an operation in flight");

endmodule

// ===== rtl/rtc_ctrl.sv =====
// Controller state machine for the reference-counted tag cache.
module rtc_ctrl import rtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_take;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    // result register can take a new beat this cycle
    assign out_free    = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.load = 1'b1;
                    n_state    = (t_kind'(i_kind) == K_PUT) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/rtc_dpath.sv =====
// Datapath for the reference-counted tag cache: slot table, scan and result register.
module rtc_dpath import rtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key,
    input  logic [3:0]  i_slot,
    output t_sts        o_sts,
    output logic        o_status,
    output logic [3:0]  o_slot_out,
    output logic [15:0] o_count_out
);

    // Slot table
    logic [ENTRIES-1:0]    r_valid;
    logic [31:0]           r_keys [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt  [ENTRIES];

    // Captured beat
    t_kind       r_kind;
    logic [31:0] r_key;
    logic [3:0]  r_slot;

    // Scan state: lowest match, lowest free slot, lowest zero-count slot
    logic [IDX_W-1:0] r_idx;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_zero;
    logic [IDX_W-1:0] r_zero_idx;

    logic [IDX_W-1:0]      rd_idx;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  slot_ok;
    logic                  cur_hit;

    logic                  wr_cnt_en;
    logic                  wr_key_en;
    logic                  set_valid;
    logic                  clr_valid;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  res_ok;

    assign o_sts.scan_last = (r_idx == IDX_W'(ENTRIES - 1));

    // Single count read port: scan slot, put slot or matched slot
    always_comb begin
        if (i_cmd.step) begin
            rd_idx = r_idx;
        end else if (r_kind == K_PUT) begin
            rd_idx = IDX_W'(r_slot);
        end else begin
            rd_idx = r_hit_idx;
        end
    end

    assign rd_cnt  = r_cnt[rd_idx];
    assign slot_ok = (32'(r_slot) < 32'(ENTRIES));
    assign cur_hit = r_valid[r_idx] && (r_keys[r_idx] == r_key);

    // Operation commit
    always_comb begin
        wr_cnt_en = 1'b0;
        wr_key_en = 1'b0;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        wr_idx    = r_hit_idx;
        wr_cnt    = rd_cnt;
        res_ok    = 1'b0;
        unique case (r_kind)
            K_GET, K_ALLOC: begin
                if (r_hit) begin
                    wr_cnt_en = 1'b1;
                    wr_cnt    = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
                    res_ok    = 1'b1;
                end else if ((r_kind == K_ALLOC) && (r_free || r_zero)) begin
                    wr_idx    = r_free ? r_free_idx : r_zero_idx;
                    wr_cnt_en = 1'b1;
                    wr_key_en = 1'b1;
                    set_valid = 1'b1;
                    wr_cnt    = COUNT_BITS'(1);
                    res_ok    = 1'b1;
                end
            end
            K_PUT: begin
                wr_idx = IDX_W'(r_slot);
                if (slot_ok) begin
                    wr_cnt_en = 1'b1;
                    wr_cnt    = (rd_cnt == '0) ? rd_cnt : rd_cnt - 1'b1;
                    res_ok    = 1'b1;
                end
            end
            K_EVICT: begin
                if (r_hit && (rd_cnt == '0)) begin
                    clr_valid = 1'b1;
                    wr_cnt    = '0;
                    res_ok    = 1'b1;
                end
            end
            default: begin
                res_ok = 1'b0;
            end
        endcase
    end

    // Beat capture, scan bookkeeping, valid flags and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_idx      <= '0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_zero     <= 1'b0;
            r_hit_idx  <= '0;
            r_free_idx <= '0;
            r_zero_idx <= '0;
            for (int e = 0; e < ENTRIES; e++) begin
                r_cnt[e] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_zero <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
                if (!r_hit && cur_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                end
                if (!r_free && !r_valid[r_idx]) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_idx;
                end
                if (!r_zero && (rd_cnt == '0)) begin
                    r_zero     <= 1'b1;
                    r_zero_idx <= r_idx;
                end
            end
            if (i_cmd.apply) begin
                if (wr_cnt_en) begin
                    r_cnt[wr_idx] <= wr_cnt;
                end
                if (set_valid) begin
                    r_valid[wr_idx] <= 1'b1;
                end
                if (clr_valid) begin
                    r_valid[wr_idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers: captured beat, keys and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_key;
            r_slot <= i_slot;
        end
        if (i_cmd.apply) begin
            if (wr_key_en) begin
                r_keys[wr_idx] <= r_key;
            end
            o_status    <= !res_ok;
            o_slot_out  <= res_ok ? 4'(wr_idx) : 4'd0;
            o_count_out <= res_ok ? 16'(wr_cnt) : 16'd0;
        end
    end

endmodule

// ===== bench/tb_refcounted_tag_cache.sv =====
// Self-checking testbench for the reference-counted tag cache.
`timescale 1ns / 100ps

module tb_refcounted_tag_cache;
    import rtc_pkg::*;

    // One result beat as the block reports it
    typedef struct packed {
        logic        status;
        logic [3:0]  slot;
        logic [15:0] count;
    } t_cache_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [31:0] i_key;
    logic [3:0]  i_slot;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_status;
    logic [3:0]  o_slot_out;
    logic [15:0] o_count_out;

    // Shadow copy of the table, updated as each beat is accepted
    logic                  slot_valid [ENTRIES];
    logic [31:0]           slot_key   [ENTRIES];
    logic [COUNT_BITS-1:0] slot_refs  [ENTRIES];

    t_cache_result pending_results [$];

    int send_idle_pct = 22;
    int recv_idle_pct = 22;
    int hold_req_cnt  = 0;

    int mismatch_count  = 0;
    int results_checked = 0;
    int saturated_seen  = 0;
    int full_allocs     = 0;
    int slot_reuses     = 0;
    int busy_evicts     = 0;
    int beat_count [4]  = '{0, 0, 0, 0};

    refcounted_tag_cache u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_slot      (i_slot),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_slot_out  (o_slot_out),
        .o_count_out (o_count_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the shadow table and return the result it should give
    function automatic t_cache_result predict_cache_op(t_kind kind, logic [31:0] key,
                                                       logic [3:0] slot);
        t_cache_result r;
        int hit;
        int pick;
        r.status = 1'b1;
        r.slot   = '0;
        r.count  = '0;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
        case (kind)
            K_GET, K_ALLOC: begin
                if (hit >= 0) begin
                    if (slot_refs[hit] != CNT_MAX) slot_refs[hit]++;
                    r.status = 1'b0;
                    r.slot   = 4'(hit);
                    r.count  = 16'(slot_refs[hit]);
                end else if (kind == K_ALLOC) begin
                    // lowest free slot first, then lowest unreferenced one
                    pick = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (pick < 0 && !slot_valid[i]) pick = i;
                    if (pick < 0) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (pick < 0 && slot_refs[i] == '0) pick = i;
                        if (pick >= 0) slot_reuses++;
                    end
                    if (pick < 0) begin
                        full_allocs++;
                    end else begin
                        slot_valid[pick] = 1'b1;
                        slot_key[pick]   = key;
                        slot_refs[pick]  = COUNT_BITS'(1);
                        r.status = 1'b0;
                        r.slot   = 4'(pick);
                        r.count  = 16'(slot_refs[pick]);
                    end
                end
            end
            K_PUT: begin
                if (int'(slot) < ENTRIES) begin
                    if (slot_refs[slot] != '0) slot_refs[slot]--;
                    r.status = 1'b0;
                    r.slot   = slot;
                    r.count  = 16'(slot_refs[slot]);
                end
            end
            default: begin
                // evict: only an unreferenced match is dropped
                if (hit >= 0 && slot_refs[hit] == '0) begin
                    slot_valid[hit] = 1'b0;
                    r.status = 1'b0;
                    r.slot   = 4'(hit);
                end else if (hit >= 0) begin
                    busy_evicts++;
                end
            end
        endcase
        return r;
    endfunction

    // Offer one beat, wait for acceptance, queue its expected result.
    // Returns just after the accepting rising edge; valid stays high until the
    // next falling edge so back-to-back beats need no gap.
    task automatic send_beat(input t_kind kind, input logic [31:0] key,
                             input logic [3:0] slot);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        i_slot     <= slot;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_cache_op(kind, key, slot));
        beat_count[kind]++;
    endtask

    // Receiver: random stalls, plus a long hold when a test asks for one
    always @(negedge i_clk) begin
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = 200;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_cache_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing outstanding:", $time,
                         " status %0d slot %0d count %0d",
                         o_status, o_slot_out, o_count_out);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_status !== want.status || o_slot_out !== want.slot ||
                    o_count_out !== want.count) begin
                    mismatch_count++;
                    $display("%0t: mismatch expected status %0d slot %0d count %0d,",
                             $time, want.status, want.slot, want.count,
                             " got status %0d slot %0d count %0d",
                             o_status, o_slot_out, o_count_out);
                end
                if (want.status == 1'b0 && want.count == 16'(CNT_MAX)) saturated_seen++;
            end
        end
    end

    // Empty-table behavior, hits, releases and refused evictions
    task automatic test_directed();
        send_beat(K_GET,   32'h0000_0000, 4'd0);
        send_beat(K_EVICT, 32'hFFFF_FFFF, 4'd0);
        send_beat(K_PUT,   32'h0000_0000, 4'd0);     // free slot, count stays zero
        send_beat(K_PUT,   32'hFFFF_FFFF, 4'd15);
        send_beat(K_ALLOC, 32'h0000_0000, 4'd0);
        send_beat(K_ALLOC, 32'hFFFF_FFFF, 4'd15);
        send_beat(K_ALLOC, 32'h0000_0000, 4'd0);     // alloc that hits
        send_beat(K_GET,   32'hFFFF_FFFF, 4'd0);
        send_beat(K_EVICT, 32'h0000_0000, 4'd0);     // still referenced
        send_beat(K_PUT,   32'h0000_0000, 4'd0);
        send_beat(K_PUT,   32'h0000_0000, 4'd0);
        send_beat(K_PUT,   32'h0000_0000, 4'd0);     // put on zero count
        send_beat(K_EVICT, 32'h0000_0000, 4'd0);
        send_beat(K_GET,   32'h0000_0000, 4'd0);     // miss after evict
        send_beat(K_ALLOC, 32'hA5A5_A5A5, 4'd9);
    endtask

    // Fill every slot, see alloc refused, then reuse an unreferenced slot
    task automatic test_table_full();
        for (int n = 0; n < 15; n++)
            send_beat(K_ALLOC, 32'h1000_0000 + n, 4'(n));
        send_beat(K_ALLOC, 32'h2000_0000, 4'd0);
        send_beat(K_PUT,   32'h0000_0000, 4'd7);
        send_beat(K_ALLOC, 32'h2000_0001, 4'd0);
        send_beat(K_GET,   slot_key[7] == 32'h2000_0001 ? 32'h1000_0005 : 32'h1000_0000,
                  4'd0);
    endtask

    // Hold the result side while beats keep coming so the block backs up
    task automatic test_back_pressure();
        send_idle_pct = 0;
        hold_req_cnt++;
        for (int n = 0; n < 12; n++) begin
            if (n % 3 == 2)
                send_beat(K_PUT, 32'h0, 4'($urandom_range(15)));
            else if (n % 2 == 0)
                send_beat(K_GET, 32'h1000_0000 + $urandom_range(15), 4'd0);
            else
                send_beat(K_ALLOC, 32'h3000_0000 + $urandom_range(3), 4'd0);
        end
        send_idle_pct = 22;
    endtask

    // Random traffic over a small key pool, alternating fill-heavy and drain-heavy chunks
    task automatic test_random_mix();
        logic [31:0] key_pool [24];
        int    roll;
        t_kind kind;
        logic [31:0] key;
        foreach (key_pool[p]) key_pool[p] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int chunk = 0; chunk < 11; chunk++) begin
            // one chunk runs with both sides flat out
            send_idle_pct = (chunk == 4) ? 0 : 22;
            recv_idle_pct = (chunk == 4) ? 0 : 22;
            for (int p = 0; p < 4; p++) key_pool[$urandom_range(23, 2)] = $urandom;
            for (int n = 0; n < 142; n++) begin
                roll = $urandom_range(99);
                if (chunk % 2 == 0) begin
                    if (roll < 45)      kind = K_ALLOC;
                    else if (roll < 65) kind = K_GET;
                    else if (roll < 85) kind = K_PUT;
                    else                kind = K_EVICT;
                end else begin
                    if (roll < 15)      kind = K_ALLOC;
                    else if (roll < 30) kind = K_GET;
                    else if (roll < 75) kind = K_PUT;
                    else                kind = K_EVICT;
                end
                key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(23)] : $urandom;
                send_beat(kind, key, 4'($urandom_range(15)));
            end
        end
        send_idle_pct = 22;
        recv_idle_pct = 22;
    endtask

    // Climb one slot's count with a run of hits, then release and take again
    task automatic test_count_climb();
        int target;
        target = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (target < 0 && slot_valid[i]) target = i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (target < 0) begin
            // empty table: the alloc lands in slot 0
            send_beat(K_ALLOC, 32'h0BAD_F00D, 4'd0);
            target = 0;
        end
        for (int n = 0; n < 40 && slot_refs[target] != CNT_MAX; n++)
            send_beat(K_GET, slot_key[target], 4'd0);
        send_beat(K_PUT, 32'h0, 4'(target));
        send_beat(K_GET, slot_key[target], 4'd0);
        send_beat(K_ALLOC, slot_key[target], 4'd0);
        send_idle_pct = 22;
        recv_idle_pct = 22;
    endtask

    // Let every outstanding result come back, then watch a while for strays
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = K_GET;
        i_key       = '0;
        i_slot      = '0;
        i_out_stall = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_refs[i]  = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_back_pressure();
        test_random_mix();
        test_count_climb();
        wait_drain();

        $display("Covered %0d get, %0d alloc, %0d put and %0d evict beats; %0d results checked.",
                 beat_count[K_GET], beat_count[K_ALLOC], beat_count[K_PUT],
                 beat_count[K_EVICT], results_checked);
        $display("Saw %0d saturated counts, %0d refused allocs, %0d slot reuses, %0d refused evicts.",
                 saturated_seen, full_allocs, slot_reuses, busy_evicts);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
